// File: rtl/hed_pkg.sv
// Shared types and constants for the HTML entity decoder.
// Holds the entity table, the hold-store and result-burst structs.
// No dependencies.
package hed_pkg;

    localparam int HOLD_DEPTH  = 6;
    localparam int BURST_DEPTH = 7;
    localparam int ENT_COUNT   = 8;
    localparam int ENT_CHARS   = 7;

    localparam logic [7:0] AMP_CHAR = 8'h26;
    localparam logic [2:0] ENT_AMP  = 3'd1;

    typedef struct packed {
        logic [0:ENT_CHARS-1][7:0] text;
        logic [2:0]                len;
        logic [7:0]                repl;
        logic                      after_amp;
    } t_entity;

    typedef struct packed {
        logic [0:HOLD_DEPTH-1][7:0] bytes;
        logic [2:0]                 cnt;
        logic                       from_amp;
    } t_hold;

    typedef struct packed {
        logic [0:BURST_DEPTH-1][7:0] bytes;
        logic [2:0]                  cnt;
        logic                        last;
    } t_burst;

    localparam t_entity ENTITY_TABLE [0:ENT_COUNT-1] = '{
        '{text: '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00},
          len: 3'd6, repl: 8'h22, after_amp: 1'b0},
        '{text: '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00},
          len: 3'd5, repl: 8'h26, after_amp: 1'b0},
        '{text: '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00},
          len: 3'd6, repl: 8'h27, after_amp: 1'b1},
        '{text: '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
          len: 3'd4, repl: 8'h3C, after_amp: 1'b1},
        '{text: '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
          len: 3'd4, repl: 8'h3E, after_amp: 1'b1},
        '{text: '{8'h26, 8'h23, 8'h38, 8'h32, 8'h31, 8'h37, 8'h3B},
          len: 3'd7, repl: 8'h27, after_amp: 1'b1},
        '{text: '{8'h26, 8'h23, 8'h38, 8'h32, 8'h31, 8'h36, 8'h3B},
          len: 3'd7, repl: 8'h27, after_amp: 1'b1},
        '{text: '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00, 8'h00},
          len: 3'd5, repl: 8'h27, after_amp: 1'b1}
    };

endpackage

// File: rtl/hed_match.sv
// Combinational entity matcher: one input byte against the hold store.
// Produces the result burst and the next hold state. Uses hed_pkg.
module hed_match
    import hed_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    input  t_hold      i_hold,
    output t_burst     o_burst,
    output t_hold      o_hold
);

    logic [7:0] cand [0:ENT_CHARS-1];
    logic [2:0] len;
    logic       any_full;
    logic       any_part;
    logic [2:0] full_idx;
    logic       ok;
    logic [7:0] res [0:BURST_DEPTH-1];
    logic [2:0] rcnt;
    t_hold      nh;
    logic [2:0] src;
    logic [3:0] total;

    always_comb begin
        len = i_hold.cnt + 3'd1;
        for (int j = 0; j < ENT_CHARS; j++) begin
            if (j < HOLD_DEPTH && 3'(j) < i_hold.cnt) begin
                cand[j] = i_hold.bytes[j];
            end else begin
                cand[j] = i_byte;
            end
        end

        any_full = 1'b0;
        any_part = 1'b0;
        full_idx = '0;
        for (int k = 0; k < ENT_COUNT; k++) begin
            ok = 1'b1;
            if (i_hold.from_amp && !ENTITY_TABLE[k].after_amp) begin
                ok = 1'b0;
            end
            if (ENTITY_TABLE[k].len < len) begin
                ok = 1'b0;
            end
            for (int j = 0; j < ENT_CHARS; j++) begin
                if (3'(j) < len && ENTITY_TABLE[k].text[j] != cand[j]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                if (ENTITY_TABLE[k].len == len) begin
                    any_full = 1'b1;
                    full_idx = 3'(k);
                end else begin
                    any_part = 1'b1;
                end
            end
        end

        nh   = i_hold;
        rcnt = '0;
        for (int i = 0; i < BURST_DEPTH; i++) begin
            res[i] = i_byte;
        end

        if (i_hold.cnt == 3'd0) begin
            if (i_byte == AMP_CHAR) begin
                nh.bytes[0] = AMP_CHAR;
                nh.cnt      = 3'd1;
                nh.from_amp = 1'b0;
            end else begin
                rcnt = 3'd1;
            end
        end else if (any_full) begin
            if (full_idx == ENT_AMP) begin
                nh.bytes[0] = AMP_CHAR;
                nh.cnt      = 3'd1;
                nh.from_amp = 1'b1;
            end else begin
                res[0]      = ENTITY_TABLE[full_idx].repl;
                rcnt        = 3'd1;
                nh.cnt      = 3'd0;
                nh.from_amp = 1'b0;
            end
        end else if (any_part && len <= 3'(HOLD_DEPTH)) begin
            nh.bytes[i_hold.cnt] = i_byte;
            nh.cnt               = len;
        end else begin
            for (int j = 0; j < HOLD_DEPTH; j++) begin
                res[j] = i_hold.bytes[j];
            end
            nh.from_amp = 1'b0;
            if (i_byte == AMP_CHAR) begin
                rcnt        = i_hold.cnt;
                nh.bytes[0] = AMP_CHAR;
                nh.cnt      = 3'd1;
            end else begin
                res[i_hold.cnt] = i_byte;
                rcnt            = len;
                nh.cnt          = 3'd0;
            end
        end

        for (int i = 0; i < BURST_DEPTH; i++) begin
            src = 3'(i) - rcnt;
            if (3'(i) < rcnt || !i_eot) begin
                o_burst.bytes[i] = res[i];
            end else if (src < 3'(HOLD_DEPTH)) begin
                o_burst.bytes[i] = nh.bytes[src];
            end else begin
                o_burst.bytes[i] = res[i];
            end
        end

        total = {1'b0, rcnt} + {1'b0, nh.cnt};
        o_hold = nh;
        if (i_eot) begin
            o_burst.cnt   = total[2:0];
            o_burst.last  = 1'b1;
            o_hold.cnt    = 3'd0;
            o_hold.from_amp = 1'b0;
        end else begin
            o_burst.cnt  = rcnt;
            o_burst.last = 1'b0;
        end
    end

endmodule

// File: rtl/hed_outbuf.sv
// Result burst register: loads up to seven bytes at once, drains one per cycle while popped.
// Marks the final byte of a text. Uses hed_pkg.
module hed_outbuf
    import hed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    input  logic       i_pop,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_valid,
    output logic [2:0] o_cnt
);

    logic [7:0] r_buf [0:BURST_DEPTH-1];
    logic [2:0] r_cnt;
    logic       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_last <= 1'b0;
        end else if (i_load) begin
            r_cnt  <= i_burst.cnt;
            r_last <= i_burst.last;
        end else if (i_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < BURST_DEPTH; i++) begin
                r_buf[i] <= i_burst.bytes[i];
            end
        end else if (i_pop) begin
            for (int i = 0; i < BURST_DEPTH - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_byte  = r_buf[0];
    assign o_valid = (r_cnt != 3'd0);
    assign o_last  = r_last && (r_cnt == 3'd1);
    assign o_cnt   = r_cnt;

endmodule

// File: rtl/html_entity_decoder_core.sv
// HTML entity decoder top level: hold-store registers, matcher and result burst.
// The first result of an item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle while each item gives at most one byte and the
// output is ready; an item that gives more bytes holds the input as the burst drains.
// Reset is synchronous, active low, and empties the hold store and the burst.
module html_entity_decoder_core
    import hed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_text
);

    t_hold      r_hold;
    t_hold      n_hold;
    t_burst     burst;
    logic       accept;
    logic       pop;
    logic [2:0] out_cnt;

    hed_match u_match (
        .i_byte  (i_in_byte),
        .i_eot   (i_end_of_text),
        .i_hold  (r_hold),
        .o_burst (burst),
        .o_hold  (n_hold)
    );

    assign pop        = o_out_valid && i_out_ready;
    assign o_in_ready = (out_cnt == 3'd0) || (out_cnt == 3'd1 && i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.cnt      <= '0;
            r_hold.from_amp <= 1'b0;
        end else if (accept) begin
            r_hold <= n_hold;
        end
    end

    hed_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_burst (burst),
        .i_pop   (pop),
        .o_byte  (o_out_byte),
        .o_last  (o_last_of_text),
        .o_valid (o_out_valid),
        .o_cnt   (out_cnt)
    );

endmodule

// File: rtl/hed_checker.sv
// Port-level checker for the HTML entity decoder, bound to the top level.
// Depends only on the top-level ports.
module hed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_end_of_text,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_text
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_end_of_text) |=> o_out_valid)
        else $error("End of text gave no result item.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("Input stalled with no result item pending.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_last_of_text)))
        else $error("Stalled result item changed.");

endmodule

bind html_entity_decoder_core hed_checker u_hed_checker (.*);
